[rtl/core/opq_pkg.sv]
`timescale 1ns / 1ps

package opq_pkg;

  // Default sizing
  localparam int unsigned CAPACITY_DEF         = 16;
  localparam int unsigned MAX_PACKET_BYTES_DEF = 64;

  // Operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_DATA         = 3'd0;
  localparam logic [2:0] ST_ACCEPTED     = 3'd1;
  localparam logic [2:0] ST_REJECTED     = 3'd2;
  localparam logic [2:0] ST_EMPTY        = 3'd3;
  localparam logic [2:0] ST_CLOSED_EMPTY = 3'd4;
  localparam logic [2:0] ST_DONE         = 3'd5;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic        last_out;
    logic [4:0]  queued_packets;
    logic [31:0] dropped_packets;
  } out_item_t;

endpackage

[rtl/core/overwriting_packet_queue.sv]
`timescale 1ns / 1ps

// Ring queue of byte packets that overwrites its oldest packet when full. The final byte
// of a push, a close, a clear and a pop of an empty queue each return one item. A pop of
// a held packet of N bytes returns N items in steps: the length memory is read when the
// pop is taken, the length is taken in, the byte memory is started, then one byte per
// cycle from the single read port of the byte memory, unless the output stalls. Inputs
// are held off while a pop streams. The stores need no clearing after reset, so the
// block takes items right away.
module overwriting_packet_queue #(
  parameter int unsigned CAPACITY         = opq_pkg::CAPACITY_DEF,
  parameter int unsigned MAX_PACKET_BYTES = opq_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  opq_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output opq_pkg::out_item_t out_item_o
);

  localparam int unsigned SLOTS  = CAPACITY + 1;
  localparam int unsigned SW     = $clog2(SLOTS);
  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned LW     = $clog2(MAX_PACKET_BYTES + 1);
  localparam int unsigned IW     = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
  localparam int unsigned BAW    = SW + IW;
  localparam int unsigned BDEPTH = SLOTS * (2 ** IW);

  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [LW-1:0] MAX_C     = LW'(MAX_PACKET_BYTES);

  // Sequencer states
  localparam logic [1:0] S_IDLE       = 2'd0;
  localparam logic [1:0] S_POP_LEN    = 2'd1;
  localparam logic [1:0] S_POP_STREAM = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [SW-1:0] head_q, head_d, tail_q, tail_d, pop_slot_q, pop_slot_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   drop_q, drop_d;
  logic [LW-1:0] inc_len_q, inc_len_d;
  logic          too_long_q, too_long_d;
  logic          closed_q, closed_d;
  logic [LW-1:0] len_q, len_d, rd_idx_q, rd_idx_d;
  logic          rd_pend_q, rd_pend_d, rd_last_q, rd_last_d;
  logic          out_valid_q, out_valid_d;
  opq_pkg::out_item_t out_q, out_d;

  logic          accept;
  logic [SW-1:0] head_next, tail_next;
  logic [LW-1:0] new_len, len_clamp;
  logic          new_long, commit_ok, move, issue;
  logic          load;
  logic [2:0]    res_status;
  logic [7:0]    res_byte;
  logic          res_last;

  logic           byte_we, byte_re, len_we, len_re;
  logic [7:0]     byte_rdata;
  logic [LW-1:0]  len_rdata;
  logic [BAW-1:0] byte_waddr, byte_raddr;

  assign accept    = in_valid_i && !in_stall_o;
  assign head_next = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;

  assign byte_waddr = {tail_q, inc_len_q[IW-1:0]};
  assign byte_raddr = {pop_slot_q, rd_idx_q[IW-1:0]};
  assign len_clamp  = (len_rdata > MAX_C) ? MAX_C : len_rdata;

  // Packet bytes, one row of 2**IW bytes per slot
  opq_ram #(
    .WIDTH (8),
    .DEPTH (BDEPTH),
    .AW    (BAW)
  ) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (byte_we),
    .waddr_i (byte_waddr),
    .wdata_i (in_item_i.data_byte),
    .re_i    (byte_re),
    .raddr_i (byte_raddr),
    .rdata_o (byte_rdata)
  );

  // Packet lengths, one per slot
  opq_ram #(
    .WIDTH (LW),
    .DEPTH (SLOTS),
    .AW    (SW)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (tail_q),
    .wdata_i (new_len),
    .re_i    (len_re),
    .raddr_i (head_q),
    .rdata_o (len_rdata)
  );

  // Input is taken only when idle and the output register frees up
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);

  // Sequencer and queue bookkeeping. Accesses to a slot never overlap: a pop
  // finishes streaming before the next item is taken.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    pop_slot_d  = pop_slot_q;
    count_d     = count_q;
    drop_d      = drop_q;
    inc_len_d   = inc_len_q;
    too_long_d  = too_long_q;
    closed_d    = closed_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    rd_pend_d   = rd_pend_q;
    rd_last_d   = rd_last_q;
    byte_we     = 1'b0;
    byte_re     = 1'b0;
    len_we      = 1'b0;
    len_re      = 1'b0;
    new_len     = inc_len_q;
    new_long    = too_long_q;
    commit_ok   = 1'b0;
    move        = 1'b0;
    issue       = 1'b0;
    load        = 1'b0;
    res_status  = opq_pkg::ST_DONE;
    res_byte    = 8'd0;
    res_last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_item_i.operation)
            opq_pkg::OP_PUSH: begin
              // Store the byte unless the packet already holds MAX_PACKET_BYTES bytes
              if (inc_len_q != MAX_C) begin
                byte_we = 1'b1;
                new_len = inc_len_q + 1'b1;
              end else begin
                new_long = 1'b1;
              end
              inc_len_d  = new_len;
              too_long_d = new_long;
              if (in_item_i.last_byte) begin
                commit_ok = !closed_q && !new_long && (new_len != '0);
                if (commit_ok) begin
                  len_we = 1'b1;
                  tail_d = tail_next;
                  if (count_q >= CAP_C) begin
                    // Full: drop the oldest packet
                    head_d = head_next;
                    if (drop_q != '1) begin
                      drop_d = drop_q + 32'd1;
                    end
                  end else begin
                    count_d = count_q + 1'b1;
                  end
                end
                inc_len_d  = '0;
                too_long_d = 1'b0;
                load       = 1'b1;
                res_status = commit_ok ? opq_pkg::ST_ACCEPTED : opq_pkg::ST_REJECTED;
              end
            end
            opq_pkg::OP_POP: begin
              if (count_q == '0) begin
                load       = 1'b1;
                res_status = closed_q ? opq_pkg::ST_CLOSED_EMPTY : opq_pkg::ST_EMPTY;
              end else begin
                len_re     = 1'b1;
                pop_slot_d = head_q;
                head_d     = head_next;
                count_d    = count_q - 1'b1;
                state_d    = S_POP_LEN;
              end
            end
            opq_pkg::OP_CLOSE: begin
              closed_d = 1'b1;
              load     = 1'b1;
            end
            default: begin
              head_d     = '0;
              tail_d     = '0;
              count_d    = '0;
              drop_d     = '0;
              closed_d   = 1'b0;
              inc_len_d  = '0;
              too_long_d = 1'b0;
              load       = 1'b1;
            end
          endcase
        end
      end

      S_POP_LEN: begin
        // Length is back; the output register is known empty here
        if (len_clamp == '0) begin
          load       = 1'b1;
          res_status = opq_pkg::ST_EMPTY;
          state_d    = S_IDLE;
        end else begin
          len_d     = len_clamp;
          rd_idx_d  = '0;
          rd_pend_d = 1'b0;
          state_d   = S_POP_STREAM;
        end
      end

      S_POP_STREAM: begin
        // Read data waits in the RAM output until the output register frees
        move  = rd_pend_q && (!out_valid_q || !out_stall_i);
        issue = (rd_idx_q != len_q) && (!rd_pend_q || move);
        if (issue) begin
          byte_re   = 1'b1;
          rd_idx_d  = rd_idx_q + 1'b1;
          rd_last_d = (rd_idx_q == len_q - 1'b1);
          rd_pend_d = 1'b1;
        end else if (move) begin
          rd_pend_d = 1'b0;
        end
        if (move) begin
          load       = 1'b1;
          res_status = opq_pkg::ST_DATA;
          res_byte   = byte_rdata;
          res_last   = rd_last_q;
          if (rd_last_q) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Output register
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    out_d = out_q;
    if (load) begin
      out_d.status          = res_status;
      out_d.out_byte        = res_byte;
      out_d.last_out        = res_last;
      out_d.queued_packets  = 5'(count_d);
      out_d.dropped_packets = drop_d;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      drop_q      <= '0;
      inc_len_q   <= '0;
      too_long_q  <= 1'b0;
      closed_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      inc_len_q   <= inc_len_d;
      too_long_q  <= too_long_d;
      closed_q    <= closed_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and pop bookkeeping
  always_ff @(posedge clk_i) begin
    pop_slot_q <= pop_slot_d;
    len_q      <= len_d;
    rd_idx_q   <= rd_idx_d;
    rd_last_q  <= rd_last_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  // Held packet count stays within capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("packet count above capacity");

  // Incoming bytes never land in the slot of the oldest held packet
  a_spare_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_we && count_q != '0) |-> (tail_q != head_q))
    else $error("push overwrites a held packet");

  // A pending read byte exists only while streaming
  a_pend_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == S_POP_STREAM))
    else $error("read byte pending outside a pop");

  // Stream reads never pass the packet length
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_STREAM) |-> (rd_idx_q <= len_q && len_q != '0))
    else $error("pop read index past packet length");

  // A result is never loaded over one that is still stalled
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load)
    else $error("output register overrun");
`endif

endmodule

[rtl/core/opq_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port synchronous RAM, one write and one registered read port
module opq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
